[design/nmef_pkg.sv]
// Package for the normal-map emboss filter: payload structs, register indexes, constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package nmef_pkg;
    typedef struct packed {
        logic       is_flush;
        logic [7:0] in_alpha;
        logic [7:0] in_blue;
        logic [7:0] in_green;
        logic [7:0] in_red;
    } t_in_item;

    typedef struct packed {
        logic       last_of_frame;
        logic [7:0] out_alpha;
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
    } t_out_item;

    // front-to-back work item: center pixel, window sums, border class
    typedef struct packed {
        logic [31:0] pix;
        logic [9:0]  lsum;
        logic [9:0]  rsum;
        logic [9:0]  tsum;
        logic [9:0]  bsum;
        logic        border;
        logic        last;
    } t_work;

    localparam logic [2:0] REG_COEF_RED   = 3'd0;
    localparam logic [2:0] REG_COEF_GREEN = 3'd1;
    localparam logic [2:0] REG_COEF_BLUE  = 3'd2;
    localparam logic [2:0] REG_WIDTH      = 3'd3;
    localparam logic [2:0] REG_HEIGHT     = 3'd4;
    localparam int CFG_W = 11;
    localparam logic [10:0] BIAS = 11'd128;
    localparam logic [10:0] SAT  = 11'd255;
endpackage
`default_nettype wire

[design/nmef_back.sv]
// Back end: turns work items into output pixels, with an output register.
// Depends on nmef_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nmef_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    input  nmef_pkg::t_work  i_work,
    output logic             o_ready,
    output logic             o_empty,
    input  wire              i_pop,
    output nmef_pkg::t_out_item o_item
);
    logic r_full;
    nmef_pkg::t_out_item r_item, n_item;

    function automatic logic [7:0] clamp(input logic signed [11:0] v);
        if (v < 0) return 8'd0;
        if (v > 12'sd255) return 8'd255;
        return v[7:0];
    endfunction

    logic [7:0] pr, pg, pb, pa, mx;
    logic signed [11:0] hs, vs;
    always_comb begin
        pr = i_work.pix[7:0];
        pg = i_work.pix[15:8];
        pb = i_work.pix[23:16];
        pa = i_work.pix[31:24];
        mx = pr;
        if (pg > mx) mx = pg;
        if (pb > mx) mx = pb;
        hs = $signed({2'b0, i_work.rsum}) - $signed({2'b0, i_work.lsum}) + 12'sd128;
        vs = $signed({2'b0, i_work.tsum}) - $signed({2'b0, i_work.bsum}) + 12'sd128;
        n_item.out_alpha     = pa;
        n_item.last_of_frame = i_work.last;
        if (pa == 8'd0) begin
            n_item.out_red   = pr;
            n_item.out_green = pg;
            n_item.out_blue  = pb;
        end else begin
            n_item.out_blue  = clamp($signed({4'b0, mx}) + 12'sd128);
            n_item.out_red   = i_work.border ? 8'd0 : clamp(hs);
            n_item.out_green = i_work.border ? 8'd0 : clamp(vs);
        end
    end

    assign o_ready = !r_full || i_pop;
    assign o_empty = !r_full;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (o_ready) begin
            r_full <= i_valid;
        end
        if (o_ready && i_valid) r_item <= n_item;
    end
endmodule
`default_nettype wire

[design/nmef_queue.sv]
// Two-entry queue that decouples the front end from the back end.
// Depends on nmef_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nmef_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  nmef_pkg::t_work i_work,
    output logic            o_full,
    output logic            o_valid,
    output nmef_pkg::t_work o_work,
    input  wire             i_take
);
    nmef_pkg::t_work r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       do_push, do_take;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_work  = r_q[r_rp];
    assign do_push = i_push && !o_full;
    assign do_take = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= !r_wp;
            if (do_take) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_take};
        end
        if (do_push) r_q[r_wp] <= i_work;
    end
endmodule
`default_nettype wire

[design/nmef_front.sv]
// Front end: gray conversion, line buffers, 3x3 window, position tracking.
// Depends on nmef_pkg. Stage 1 reads line memories, stage 2 forms the window.
`timescale 1ns / 1ps
`default_nettype none
module nmef_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  nmef_pkg::t_in_item i_item,
    output logic              o_full,
    input  wire               i_cfg_we,
    input  wire [2:0]         i_cfg_idx,
    input  wire [10:0]        i_cfg_data,
    output logic              o_valid,
    output nmef_pkg::t_work   o_work,
    input  wire               i_q_full
);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1) + 1;
    localparam int TW = $clog2((MAX_WIDTH + 1) * (MAX_HEIGHT + 1) + 1);

    logic [8:0]  r_cr, r_cg, r_cb;
    logic [10:0] r_wreg, r_hreg;
    logic [CW-1:0] w;
    logic [HW-1:0] h;

    always_comb begin
        if (r_wreg < 11'd3) w = CW'(3);
        else if ({21'b0, r_wreg} > 32'(MAX_WIDTH)) w = CW'(MAX_WIDTH);
        else w = CW'(r_wreg);
        if (r_hreg < 11'd3) h = HW'(3);
        else if ({21'b0, r_hreg} > 32'(MAX_HEIGHT)) h = HW'(MAX_HEIGHT);
        else h = HW'(r_hreg);
    end

    // line memories
    logic [7:0]  m_above [MAX_WIDTH];
    logic [7:0]  m_mid   [MAX_WIDTH];
    logic [31:0] m_pix   [MAX_WIDTH];

    logic            r_s1v, r_s2v;
    logic [AW-1:0]   r_s1c;
    logic [7:0]      r_s1gray, r_rd_above, r_rd_mid;
    logic [31:0]     r_rd_pix, r_pend;
    logic            r_s1emit, r_s1border, r_s1last;
    logic [7:0]      r_win [9];
    logic            r_s2emit, r_s2border, r_s2last;
    logic [31:0]     r_s2pix;

    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [TW-1:0] r_taken;
    logic          restart;

    // pipeline advances only when the queue has room
    logic adv;
    assign adv    = !i_q_full;
    assign o_full = i_q_full;
    logic acc;
    assign acc = i_push && adv;
    assign restart = i_cfg_we && (i_cfg_idx == nmef_pkg::REG_WIDTH ||
                                  i_cfg_idx == nmef_pkg::REG_HEIGHT);

    logic [7:0] r, g, b, a;
    logic [19:0] gsum;
    logic [7:0]  gray;
    assign r = i_item.is_flush ? 8'd0 : i_item.in_red;
    assign g = i_item.is_flush ? 8'd0 : i_item.in_green;
    assign b = i_item.is_flush ? 8'd0 : i_item.in_blue;
    assign a = i_item.is_flush ? 8'd0 : i_item.in_alpha;
    assign gsum = 20'(r_cr * r) + 20'(r_cg * g) + 20'(r_cb * b);
    assign gray = (a == 8'd0) ? 8'd0 : ((gsum[19:8] > 12'd255) ? 8'd255 : gsum[15:8]);

    logic [RW-1:0] m;
    logic [CW-1:0] n;
    logic [CW-1:0] n_col;
    logic [RW-1:0] n_row;
    always_comb begin
        if (r_col != '0) begin
            m = r_row - RW'(1); n = r_col - CW'(1);
        end else begin
            m = r_row - RW'(2); n = w - CW'(1);
        end
        n_col = r_col + CW'(1);
        n_row = r_row;
        if (n_col >= w) begin n_col = '0; n_row = r_row + RW'(1); end
    end
    logic [AW-1:0] ca;
    assign ca = r_col[AW-1:0];

    // stage 1 memory reads; consecutive items never share a column (width is at
    // least 3), so the row-above write as each beat leaves stage 1 is never read stale
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cr <= 9'd54; r_cg <= 9'd182; r_cb <= 9'd18;
            r_wreg <= 11'd1024; r_hreg <= 11'd1024;
            r_col <= '0; r_row <= '0; r_taken <= '0;
            r_s1v <= 1'b0; r_s2v <= 1'b0; r_pend <= '0;
            for (int k = 0; k < 9; k++) r_win[k] <= 8'd0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    nmef_pkg::REG_COEF_RED:   r_cr <= i_cfg_data[8:0];
                    nmef_pkg::REG_COEF_GREEN: r_cg <= i_cfg_data[8:0];
                    nmef_pkg::REG_COEF_BLUE:  r_cb <= i_cfg_data[8:0];
                    nmef_pkg::REG_WIDTH:      r_wreg <= i_cfg_data;
                    nmef_pkg::REG_HEIGHT:     r_hreg <= i_cfg_data;
                    default: ;
                endcase
            end
            if (adv) begin
                r_s1v <= acc;
                r_s2v <= r_s1v && r_s1emit;
                if (r_s1v) begin
                    for (int k = 0; k < 6; k++) r_win[k] <= r_win[k+3];
                    r_win[6] <= r_rd_above;
                    r_win[7] <= r_rd_mid;
                    r_win[8] <= r_s1gray;
                    r_pend   <= r_rd_pix;
                end
            end
            if (acc) begin
                if (TW'(r_taken + TW'(1)) >= TW'(w * h + w + CW'(1))) begin
                    r_col <= '0; r_row <= '0; r_taken <= '0;
                end else begin
                    r_col <= n_col; r_row <= n_row; r_taken <= r_taken + TW'(1);
                end
            end
            if (restart) begin
                r_col <= '0; r_row <= '0; r_taken <= '0;
                for (int k = 0; k < 9; k++) r_win[k] <= 8'd0;
            end
        end
        if (acc) begin
            r_rd_above <= m_above[ca];
            r_rd_mid   <= m_mid[ca];
            r_rd_pix   <= m_pix[ca];
            m_mid[ca]  <= gray;
            m_pix[ca]  <= {a, b, g, r};
            r_s1c      <= ca;
            r_s1gray   <= gray;
            r_s1emit   <= 32'(r_taken) >= 32'(w) + 1;
            r_s1border <= m == '0 || m == RW'(h - HW'(1)) || n == '0 || n == w - CW'(1);
            r_s1last   <= m == RW'(h - HW'(1)) && n == w - CW'(1);
        end
        // old middle row moves up as the stage 1 beat leaves
        if (i_rst_n && adv && r_s1v) m_above[r_s1c] <= r_rd_mid;
        if (adv && r_s1v) begin
            r_s2pix    <= r_pend;
            r_s2border <= r_s1border;
            r_s2last   <= r_s1last;
            r_s2emit   <= r_s1emit;
        end
    end

    // output of stage 2: center pixel is the previously pending pixel
    always_comb begin
        o_valid       = r_s2v && adv;
        o_work.pix    = r_s2pix;
        o_work.lsum   = 10'(r_win[0]) + 10'(r_win[1]) + 10'(r_win[2]);
        o_work.rsum   = 10'(r_win[6]) + 10'(r_win[7]) + 10'(r_win[8]);
        o_work.tsum   = 10'(r_win[0]) + 10'(r_win[3]) + 10'(r_win[6]);
        o_work.bsum   = 10'(r_win[2]) + 10'(r_win[5]) + 10'(r_win[8]);
        o_work.border = r_s2border;
        o_work.last   = r_s2last && r_s2emit;
    end
endmodule
`default_nettype wire

[design/normal_map_emboss_filter_unit.sv]
// Top level of the normal-map emboss filter.
// Depends on nmef_pkg, nmef_front, nmef_queue, nmef_back.
`timescale 1ns / 1ps
`default_nettype none
// One pixel beat per clock in unless full, one result beat per clock out while popped.
// The front end reads the line memories (one read and one write port each) and forms the
// 3x3 gray window; a two-entry queue parts it from the back end, which computes gradients
// and holds the result in an output register. Results trail inputs by image_width+1
// beats, so send image_width+1 flush beats after a frame. No clearing pass at reset.
module normal_map_emboss_filter_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  push,
    output logic                 full,
    input  nmef_pkg::t_in_item   i_item,
    output logic                 empty,
    input  wire                  pop,
    output nmef_pkg::t_out_item  o_item,
    input  wire                  i_cfg_we,
    input  wire [2:0]            i_cfg_idx,
    input  wire [10:0]           i_cfg_data
);
    logic fv, qf, qv, br;
    nmef_pkg::t_work fw, qw;

    nmef_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .i_clk, .i_rst_n, .i_push(push), .i_item, .o_full(full),
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_valid(fv), .o_work(fw), .i_q_full(qf));

    nmef_queue u_queue (.i_clk, .i_rst_n, .i_push(fv), .i_work(fw), .o_full(qf),
        .o_valid(qv), .o_work(qw), .i_take(br));

    nmef_back u_back (.i_clk, .i_rst_n, .i_valid(qv), .i_work(qw), .o_ready(br),
        .o_empty(empty), .i_pop(pop), .o_item);
endmodule
`default_nettype wire
